// ===== rtl/dpm_pkg.sv =====
package dpm_pkg;

    localparam int DefTableDepth = 256;
    localparam int DefFracBits   = 16;

    localparam int TempW = 15;
    localparam int HumW  = 14;
    localparam int DewW  = 15;
    localparam int StatW = 2;

    localparam logic [StatW-1:0] StOk   = 2'd0;
    localparam logic [StatW-1:0] StZero = 2'd1;
    localparam logic [StatW-1:0] StSat  = 2'd2;

    // shift-subtract quotient, used for elaboration-time constants only
    function automatic logic [63:0] udiv(input logic [63:0] num, input logic [63:0] den);
        logic [63:0] q;
        logic [64:0] rem;
        q = '0;
        rem = '0;
        for (int b = 63; b >= 0; b--) begin
            rem = {rem[63:0], num[b]};
            if (rem >= {1'b0, den}) begin
                rem = rem - {1'b0, den};
                q[b] = 1'b1;
            end
        end
        return q;
    endfunction

    // ln(num / den) in Q32 for num >= den, by the atanh series
    function automatic logic [63:0] ln_ratio(input logic [63:0] num, input logic [63:0] den);
        logic [63:0] z;
        logic [63:0] z2;
        logic [63:0] term;
        logic [63:0] sum;
        z = udiv((num - den) << 32, num + den);
        z2 = (z * z) >> 32;
        term = z;
        sum = '0;
        for (int k = 1; k < 200; k += 2) begin
            if (term != 0) begin
                sum = sum + udiv(term, 64'(k));
                term = (term * z2) >> 32;
            end
        end
        return sum << 1;
    endfunction

    function automatic logic [63:0] ln1e4_q32();
        return 64'd13 * ln_ratio(64'd2, 64'd1) + ln_ratio(64'd10000, 64'd8192);
    endfunction

    localparam logic [63:0] Ln2Q32 = ln_ratio(64'd2, 64'd1);

endpackage

// ===== rtl/dew_point_magnus.sv =====
// Dew point by the Magnus formula, one sample per transfer.
// Slave channel: s_axis_tdata = {humidity[13:0], temperature[14:0]} (lsb first),
//   temperature signed hundredths of deg C, humidity hundredths of percent.
// Master channel: m_axis_tdata = dew[14:0] (signed hundredths of deg C),
//   m_axis_tuser = status (0 valid, 1 humidity zero, 2 saturated).
// Throughput: one sample per cycle while the receiver does not stall. m_axis_tvalid
// rises once the input transfer has passed 138 register stages: two bit-per-stage
// dividers in series (56 stages for 17.271*t/(237.7+t), then 72 for the final
// dew quotient), plus 9 operand, log and rounding stages and the output register.
// The log of humidity uses a constant table of ln(m), m in [1,2], interpolated.
// The whole pipeline advances together; when the receiver stalls (m_axis_tready
// low with a result waiting) every stage holds and s_axis_tready drops, so no
// sample is lost or repeated. A one-entry output stage sits after the pipeline.
// Synchronous reset clears all valid bits; no state crosses samples.
module dew_point_magnus #(
    parameter int LOG_TABLE_DEPTH = dpm_pkg::DefTableDepth,
    parameter int FRAC_BITS       = dpm_pkg::DefFracBits
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,   // temperature[14:0], humidity[28:15]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata,   // dew[14:0]
    output logic [1:0]  m_axis_tuser    // status[1:0]
);
    localparam int TW   = $clog2(LOG_TABLE_DEPTH);
    localparam int F    = FRAC_BITS;
    localparam int N1W  = 56;
    localparam int D1W  = 28;
    localparam int GW   = 40;
    localparam int N2W  = 72;
    localparam int D2W  = 56;
    localparam int TabN = LOG_TABLE_DEPTH + 1;
    localparam logic [63:0] LnK = dpm_pkg::ln1e4_q32();

    // ln(1 + i/depth) in Q32, entry i at bits [32*i +: 32]
    function automatic logic [32*TabN-1:0] build_tab();
        logic [32*TabN-1:0] tab;
        tab = '0;
        for (int i = 0; i < TabN; i++) begin
            tab[32*i +: 32] = 32'(dpm_pkg::ln_ratio(64'(LOG_TABLE_DEPTH + i),
                                                    64'(LOG_TABLE_DEPTH)));
        end
        return tab;
    endfunction

    localparam logic [32*TabN-1:0] LnTab = build_tab();

    logic en;
    logic r_ovld;
    assign en = !r_ovld || m_axis_tready;
    assign s_axis_tready = en;

    // stage 0: capture
    logic               r0_v;
    logic signed [14:0] r0_t;
    logic [13:0]        r0_h;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r0_v <= 1'b0;
        else if (en) r0_v <= s_axis_tvalid;
        if (en) begin
            r0_t <= s_axis_tdata[14:0];
            r0_h <= s_axis_tdata[28:15];
        end
    end

    // stage 1: operands for a, and humidity exponent
    logic signed [N1W-1:0] n1_num;
    logic [3:0]            n1_e;
    always_comb begin
        n1_num = N1W'(64'sd17271 * 64'(r0_t)) <<< F;
        n1_e = '0;
        for (int k = 0; k < 14; k++) if (r0_h[k]) n1_e = 4'(k);
    end
    logic               r1_v;
    logic               r1_neg;
    logic [N1W-1:0]     r1_num;
    logic [D1W-1:0]     r1_den;
    logic [13:0]        r1_h;
    logic [3:0]         r1_e;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r1_v <= 1'b0;
        else if (en) r1_v <= r0_v;
        if (en) begin
            r1_neg <= n1_num[N1W-1];
            r1_num <= n1_num[N1W-1] ? N1W'(-n1_num) : n1_num;
            r1_den <= D1W'(32'd1000 * 32'(32'sd23770 + 32'(r0_t)));
            r1_h   <= r0_h;
            r1_e   <= n1_e;
        end
    end

    // stage 2: add half for rounding, and table position
    logic               r2_v;
    logic [N1W-1:0]     r2_num;
    logic [D1W-1:0]     r2_den;
    logic [46:0]        r2_tag;
    logic [TW+13:0]     n2_p;
    always_comb n2_p = (TW+14)'(r1_h - (14'd1 << r1_e)) * (TW+14)'(LOG_TABLE_DEPTH);
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r2_v <= 1'b0;
        else if (en) r2_v <= r1_v;
        if (en) begin
            r2_num <= r1_num + N1W'(r1_den >> 1);
            r2_den <= r1_den;
            r2_tag <= {r1_neg, (r1_h == 0), 4'(r1_e), 41'(n2_p)};
        end
    end

    logic               d1_v;
    logic [N1W-1:0]     d1_q;
    logic [46:0]        d1_tag;
    dpm_div #(.NumW(N1W), .DenW(D1W), .TagW(47)) u_div_a (
        .i_clk, .i_rst_n, .i_en(en), .i_valid(r2_v), .i_num(r2_num),
        .i_den(r2_den), .i_tag(r2_tag), .o_valid(d1_v), .o_quo(d1_q), .o_tag(d1_tag)
    );

    // stage 3: table lookup
    logic [TW+13:0]     s3_p;
    logic [3:0]         s3_e;
    logic [TW-1:0]      s3_i;
    logic [13:0]        s3_f;
    always_comb begin
        s3_e = d1_tag[44:41];
        s3_p = d1_tag[TW+13:0];
        s3_i = TW'(s3_p >> s3_e);
        s3_f = 14'(s3_p & ((TW+14)'(1) << s3_e) - 1'b1);
    end
    logic               r3_v, r3_z;
    logic signed [GW-1:0] r3_a;
    logic [31:0]        r3_l0, r3_l1;
    logic [13:0]        r3_f;
    logic [3:0]         r3_e;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r3_v <= 1'b0;
        else if (en) r3_v <= d1_v;
        if (en) begin
            r3_z  <= d1_tag[45];
            r3_a  <= d1_tag[46] ? -GW'(d1_q) : GW'(d1_q);
            r3_l0 <= LnTab[32*int'(s3_i) +: 32];
            r3_l1 <= LnTab[32*(int'(s3_i) + 1) +: 32];
            r3_f  <= s3_f;
            r3_e  <= s3_e;
        end
    end

    // stage 4: interpolate
    logic               r4_v, r4_z;
    logic signed [GW-1:0] r4_a;
    logic [33:0]        r4_lm;
    logic [3:0]         r4_e;
    logic [45:0]        n4_m;
    always_comb begin
        n4_m = 46'(r3_l1 - r3_l0) * 46'(r3_f);
        if (r3_e != 0) n4_m = n4_m + (46'd1 << (r3_e - 1'b1));
    end
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r4_v <= 1'b0;
        else if (en) r4_v <= r3_v;
        if (en) begin
            r4_z  <= r3_z;
            r4_a  <= r3_a;
            r4_lm <= 34'(r3_l0) + 34'(n4_m >> r3_e);
            r4_e  <= r3_e;
        end
    end

    // stage 5: ln in Q32, then round to Q F
    logic signed [40:0] n5_ln;
    logic [40:0]        n5_mag;
    always_comb begin
        n5_ln  = 41'(64'(r4_e) * dpm_pkg::Ln2Q32) + 41'(r4_lm) - 41'(LnK);
        n5_mag = n5_ln[40] ? -n5_ln : n5_ln;
    end
    logic               r5_v, r5_z;
    logic signed [GW-1:0] r5_a;
    logic signed [GW-1:0] r5_ln;
    logic [40:0]        n5_q;
    always_comb n5_q = (n5_mag + (41'd1 << (31 - F))) >> (32 - F);
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r5_v <= 1'b0;
        else if (en) r5_v <= r4_v;
        if (en) begin
            r5_z  <= r4_z;
            r5_a  <= r4_a;
            r5_ln <= n5_ln[40] ? -GW'(n5_q) : GW'(n5_q);
        end
    end

    // stage 6: g
    logic               r6_v, r6_z;
    logic signed [GW-1:0] r6_g;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r6_v <= 1'b0;
        else if (en) r6_v <= r5_v;
        if (en) begin
            r6_z <= r5_z;
            r6_g <= r5_a + r5_ln;
        end
    end

    // stage 7: numerator and denominator of dew
    logic               r7_v, r7_z, r7_neg;
    logic [N2W-1:0]     r7_num;
    logic [D2W-1:0]     r7_den;
    logic signed [N2W-1:0] n7_n;
    always_comb n7_n = N2W'(r6_g) * N2W'(23770000);
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r7_v <= 1'b0;
        else if (en) r7_v <= r6_v;
        if (en) begin
            r7_z   <= r6_z;
            r7_neg <= n7_n[N2W-1];
            r7_num <= n7_n[N2W-1] ? -n7_n : n7_n;
            r7_den <= D2W'((D2W'(17271) << F) - D2W'(r6_g) * D2W'(1000));
        end
    end

    logic               r8_v;
    logic [N2W-1:0]     r8_num;
    logic [D2W-1:0]     r8_den;
    logic [1:0]         r8_tag;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r8_v <= 1'b0;
        else if (en) r8_v <= r7_v;
        if (en) begin
            r8_num <= r7_num + N2W'(r7_den >> 1);
            r8_den <= r7_den;
            r8_tag <= {r7_neg, r7_z};
        end
    end

    logic               d2_v;
    logic [N2W-1:0]     d2_q;
    logic [1:0]         d2_tag;
    dpm_div #(.NumW(N2W), .DenW(D2W), .TagW(2)) u_div_d (
        .i_clk, .i_rst_n, .i_en(en), .i_valid(r8_v), .i_num(r8_num),
        .i_den(r8_den), .i_tag(r8_tag), .o_valid(d2_v), .o_quo(d2_q), .o_tag(d2_tag)
    );

    // output stage: saturate
    localparam int DewW_L = dpm_pkg::DewW;
    logic [DewW_L-1:0]  r_dew;
    logic [1:0]         r_st;
    logic [14:0]        n_dew;
    logic [1:0]         n_st;
    always_comb begin
        n_st = dpm_pkg::StOk;
        if (d2_tag[0]) begin
            n_dew = '0;
            n_st  = dpm_pkg::StZero;
        end else if (d2_tag[1] && d2_q > N2W'(10000)) begin
            n_dew = -15'sd10000;
            n_st  = dpm_pkg::StSat;
        end else if (!d2_tag[1] && d2_q > N2W'(16383)) begin
            n_dew = 15'd16383;
            n_st  = dpm_pkg::StSat;
        end else begin
            n_dew = d2_tag[1] ? -15'(d2_q) : 15'(d2_q);
        end
    end
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_ovld <= 1'b0;
        else if (en) r_ovld <= d2_v;
        if (en) begin
            r_dew <= n_dew;
            r_st  <= n_st;
        end
    end

    assign m_axis_tvalid = r_ovld;
    assign m_axis_tdata  = {1'b0, r_dew};
    assign m_axis_tuser  = r_st;

    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ovld && !m_axis_tready |=> r_ovld && $stable(r_dew) && $stable(r_st))
        else $error("result changed while stalled");
    a_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tready == (!m_axis_tvalid || m_axis_tready))
        else $error("ready not tied to output stall");
    a_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser == dpm_pkg::StZero |-> m_axis_tdata == 16'd0)
        else $error("zero humidity result nonzero");
endmodule

// ===== rtl/dpm_div.sv =====
// Pipelined restoring divider: one quotient bit per stage.
module dpm_div #(
    parameter int NumW = 48,
    parameter int DenW = 40,
    parameter int TagW = 8
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_en,
    input  logic              i_valid,
    input  logic [NumW-1:0]   i_num,
    input  logic [DenW-1:0]   i_den,
    input  logic [TagW-1:0]   i_tag,
    output logic              o_valid,
    output logic [NumW-1:0]   o_quo,
    output logic [TagW-1:0]   o_tag
);
    localparam int RemW = DenW + 1;

    logic                     r_vld [NumW];
    logic [NumW-1:0]          r_q   [NumW];
    logic [RemW-1:0]          r_rem [NumW];
    logic [DenW-1:0]          r_den [NumW];
    logic [TagW-1:0]          r_tag [NumW];

    for (genvar s = 0; s < NumW; s++) begin : g_st
        logic            in_vld;
        logic [NumW-1:0] in_q;
        logic [RemW-1:0] in_rem;
        logic [DenW-1:0] in_den;
        logic [TagW-1:0] in_tag;
        logic [RemW:0]   n_sh;
        logic [RemW:0]   n_diff;
        if (s == 0) begin : g_head
            assign in_vld = i_valid;
            assign in_q   = i_num;
            assign in_rem = '0;
            assign in_den = i_den;
            assign in_tag = i_tag;
        end else begin : g_body
            assign in_vld = r_vld[s-1];
            assign in_q   = r_q[s-1];
            assign in_rem = r_rem[s-1];
            assign in_den = r_den[s-1];
            assign in_tag = r_tag[s-1];
        end
        always_comb begin
            n_sh   = {in_rem, in_q[NumW-1]};
            n_diff = n_sh - {2'b0, in_den};
        end
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[s] <= 1'b0;
            end else if (i_en) begin
                r_vld[s] <= in_vld;
            end
            if (i_en) begin
                r_den[s] <= in_den;
                r_tag[s] <= in_tag;
                if (!n_diff[RemW]) begin
                    r_rem[s] <= n_diff[RemW-1:0];
                    r_q[s]   <= {in_q[NumW-2:0], 1'b1};
                end else begin
                    r_rem[s] <= n_sh[RemW-1:0];
                    r_q[s]   <= {in_q[NumW-2:0], 1'b0};
                end
            end
        end
    end

    assign o_valid = r_vld[NumW-1];
    assign o_quo   = r_q[NumW-1];
    assign o_tag   = r_tag[NumW-1];
endmodule
